>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks sampled on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define UVST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define UVST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define UVST_ASSERT(lbl, prop, msg)
`define UVST_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/uvst_pkg.sv
// ----------------------------------------------------------------------------
// uvst_pkg
// Widths, operation and status codes shared by the value set table.
// ----------------------------------------------------------------------------
package uvst_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned DRAW_W  = 16;
  localparam int unsigned ST_W    = 2;
  localparam int unsigned ECNT_W  = 7;
  localparam int unsigned SUM_W   = 38;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_DUP   = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic clr;  // start a new pass
    logic acc;  // fold data into sum and max
    logic chk;  // compare data against the key
  } acc_ctrl_t;

endpackage

>>> rtl/uvst_if.sv
// ----------------------------------------------------------------------------
// uvst_if
// Request and response channels of the value set table.
// ----------------------------------------------------------------------------
interface uvst_req_if;
  logic                                  valid;
  logic                                  ready;
  logic        [uvst_pkg::OP_W-1:0]      opcode;
  logic signed [uvst_pkg::VAL_W-1:0]     value;
  logic        [uvst_pkg::DRAW_W-1:0]    random_draw;

  modport source (output valid, opcode, value, random_draw, input ready);
  modport sink   (input valid, opcode, value, random_draw, output ready);
endinterface

interface uvst_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic        [uvst_pkg::ST_W-1:0]      status;
  logic signed [uvst_pkg::VAL_W-1:0]     popped_value;
  logic                                  found;
  logic        [uvst_pkg::ECNT_W-1:0]    entry_count;
  logic signed [uvst_pkg::SUM_W-1:0]     sum_of_entries;
  logic signed [uvst_pkg::VAL_W-1:0]     max_entry;
  logic                                  max_valid;

  modport source (output valid, status, popped_value, found, entry_count,
                  sum_of_entries, max_entry, max_valid, input ready);
  modport sink   (input valid, status, popped_value, found, entry_count,
                  sum_of_entries, max_entry, max_valid, output ready);
endinterface

>>> rtl/uvst_div.sv
// ----------------------------------------------------------------------------
// uvst_div
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module uvst_div #(
  parameter int unsigned CW = 7,
  parameter int unsigned AW = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [uvst_pkg::DRAW_W-1:0]     dividend_i,
  input  logic [CW-1:0]                   divisor_i,
  output logic [AW-1:0]                   rem_o,
  output logic                            done_o
);

  localparam int unsigned DW = uvst_pkg::DRAW_W;
  localparam int unsigned SW = $clog2(DW);
  localparam logic [SW-1:0] LAST_STEP = SW'(DW - 1);

  logic [CW-1:0] rem_q, rem_d;
  logic [DW-1:0] dvd_q;
  logic [CW-1:0] div_q;
  logic [SW-1:0] step_q;
  logic          busy_q;
  logic          done_q;
  logic [CW:0]   trial;

  always_comb begin
    trial = {rem_q, dvd_q[DW-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = CW'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      dvd_q  <= '0;
      div_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
        rem_q  <= '0;
        dvd_q  <= dividend_i;
        div_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q  <= rem_d;
        dvd_q  <= {dvd_q[DW-2:0], 1'b0};
        step_q <= step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rem_o  = rem_q[AW-1:0];
  assign done_o = done_q;

endmodule

>>> rtl/uvst_acc.sv
// ----------------------------------------------------------------------------
// uvst_acc
// Running sum, maximum and key match over one pass of the table, plus an appended value.
// ----------------------------------------------------------------------------
module uvst_acc (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  uvst_pkg::acc_ctrl_t                   ctrl_i,
  input  logic signed [uvst_pkg::VAL_W-1:0]     data_i,
  input  logic signed [uvst_pkg::VAL_W-1:0]     key_i,
  output logic signed [uvst_pkg::SUM_W-1:0]     sum_o,
  output logic signed [uvst_pkg::VAL_W-1:0]     max_o,
  output logic                                  any_o,
  output logic                                  match_o
);

  localparam int unsigned VW = uvst_pkg::VAL_W;
  localparam int unsigned SW = uvst_pkg::SUM_W;

  logic signed [SW-1:0] sum_q;
  logic signed [VW-1:0] max_q;
  logic                 any_q;
  logic                 match_q;
  logic signed [SW-1:0] data_ext;

  assign data_ext = {{(SW - VW){data_i[VW-1]}}, data_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      max_q   <= '0;
      any_q   <= 1'b0;
      match_q <= 1'b0;
    end else if (ctrl_i.clr) begin
      sum_q   <= '0;
      max_q   <= '0;
      any_q   <= 1'b0;
      match_q <= 1'b0;
    end else begin
      if (ctrl_i.acc) begin
        sum_q <= sum_q + data_ext;
        any_q <= 1'b1;
        if (!any_q || (data_i > max_q)) begin
          max_q <= data_i;
        end
      end
      if (ctrl_i.chk && (data_i == key_i)) begin
        match_q <= 1'b1;
      end
    end
  end

  assign sum_o   = sum_q;
  assign max_o   = max_q;
  assign any_o   = any_q;
  assign match_o = match_q;

endmodule

>>> rtl/unique_value_set_table.sv
// ----------------------------------------------------------------------------
// unique_value_set_table
// Table of distinct signed values with insert, swap-remove pop and lookup.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request: opcode, value and random_draw. It is taken
//   only while the block is idle; one request is worked on at a time.
//   rsp_o returns one response per request: status, popped value, found
//   flag, entry count, sum of entries and maximum with its valid flag.
//   insert, lookup and an unused opcode scan the table, then update it
//   and respond. A pop on a non-empty table first runs the remainder
//   unit, then swaps through the read and write ports of the table
//   (read the chosen slot, read the last entry, write it into the chosen
//   slot), then scans, updates and responds. The scan reads the entry
//   memory one entry per cycle.
//   A pop on an empty table skips the remainder unit.
//   Reset empties the table at once; no clearing pass is needed.
//   While rsp_o is stalled the response holds and no new request is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module unique_value_set_table #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  uvst_req_if.sink   req_i,
  uvst_rsp_if.source rsp_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned VW = uvst_pkg::VAL_W;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_POP_A,
    S_POP_B,
    S_POP_C,
    S_SCAN,
    S_UPD,
    S_RESP
  } state_e;

  state_e                          state_q;
  logic [uvst_pkg::OP_W-1:0]       op_q;
  logic signed [VW-1:0]            val_q;
  logic [CW-1:0]                   count_q;
  logic [CW-1:0]                   issue_q;
  logic                            rd_vld_q;
  logic [uvst_pkg::ST_W-1:0]       status_q;
  logic signed [VW-1:0]            popped_q;
  logic                            found_q;

  logic signed [VW-1:0]            mem [CAPACITY];
  logic signed [VW-1:0]            rd_data_q;
  logic                            mem_re;
  logic                            mem_we;
  logic [AW-1:0]                   rd_addr;
  logic [AW-1:0]                   wr_addr;
  logic signed [VW-1:0]            wr_data;

  uvst_pkg::acc_ctrl_t             acc_ctrl;
  logic signed [VW-1:0]            acc_data;
  logic signed [uvst_pkg::SUM_W-1:0] acc_sum;
  logic signed [VW-1:0]            acc_max;
  logic                            acc_any;
  logic                            acc_match;

  logic                            div_start;
  logic [AW-1:0]                   div_rem;
  logic                            div_done;

  logic                            req_fire;
  logic                            scan_issue;
  logic                            scan_done;
  logic [CW-1:0]                   cnt_m1;
  logic                            do_append;

  assign req_fire   = req_i.valid && req_i.ready;
  assign scan_issue = (state_q == S_SCAN) && (issue_q < count_q);
  assign scan_done  = (state_q == S_SCAN) && !scan_issue && !rd_vld_q;
  assign cnt_m1     = count_q - 1'b1;
  assign do_append  = (op_q == uvst_pkg::OP_INSERT) && !acc_match && (count_q != CAP_CNT);

  always_comb begin
    acc_ctrl  = '0;
    acc_data  = rd_data_q;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    rd_addr   = issue_q[AW-1:0];
    wr_addr   = div_rem;
    wr_data   = rd_data_q;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          acc_ctrl.clr = 1'b1;
          div_start    = (req_i.opcode == uvst_pkg::OP_POP) && (count_q != '0);
        end
      end
      S_POP_A: begin
        rd_addr = div_rem;
        mem_re  = 1'b1;
      end
      S_POP_B: begin
        rd_addr = cnt_m1[AW-1:0];
        mem_re  = 1'b1;
      end
      S_POP_C: begin
        mem_we = 1'b1;
      end
      S_SCAN: begin
        mem_re       = scan_issue;
        acc_ctrl.acc = rd_vld_q;
        acc_ctrl.chk = rd_vld_q;
      end
      S_UPD: begin
        if (do_append) begin
          mem_we       = 1'b1;
          wr_addr      = count_q[AW-1:0];
          wr_data      = val_q;
          acc_ctrl.acc = 1'b1;
          acc_data     = val_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= uvst_pkg::OP_INSERT;
      val_q    <= '0;
      count_q  <= '0;
      issue_q  <= '0;
      rd_vld_q <= 1'b0;
      status_q <= uvst_pkg::ST_OK;
      popped_q <= '0;
      found_q  <= 1'b0;
    end else begin
      rd_vld_q <= scan_issue;
      case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            op_q     <= req_i.opcode;
            val_q    <= req_i.value;
            status_q <= uvst_pkg::ST_OK;
            popped_q <= '0;
            found_q  <= 1'b0;
            issue_q  <= '0;
            if (req_i.opcode == uvst_pkg::OP_POP) begin
              if (count_q == '0) begin
                status_q <= uvst_pkg::ST_EMPTY;
                state_q  <= S_SCAN;
              end else begin
                state_q <= S_DIV;
              end
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_POP_A;
          end
        end
        S_POP_A: begin
          state_q <= S_POP_B;
        end
        S_POP_B: begin
          popped_q <= rd_data_q;
          state_q  <= S_POP_C;
        end
        S_POP_C: begin
          count_q <= cnt_m1;
          issue_q <= '0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_issue) begin
            issue_q <= issue_q + 1'b1;
          end
          if (scan_done) begin
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          if (op_q == uvst_pkg::OP_INSERT) begin
            if (acc_match) begin
              status_q <= uvst_pkg::ST_DUP;
            end else if (count_q == CAP_CNT) begin
              status_q <= uvst_pkg::ST_FULL;
            end else begin
              count_q <= count_q + 1'b1;
            end
          end
          if (op_q == uvst_pkg::OP_LOOKUP) begin
            found_q <= acc_match;
          end
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (rsp_o.ready) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  uvst_div #(
    .CW (CW),
    .AW (AW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (req_i.random_draw),
    .divisor_i  (count_q),
    .rem_o      (div_rem),
    .done_o     (div_done)
  );

  uvst_acc u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (acc_ctrl),
    .data_i  (acc_data),
    .key_i   (val_q),
    .sum_o   (acc_sum),
    .max_o   (acc_max),
    .any_o   (acc_any),
    .match_o (acc_match)
  );

  assign req_i.ready          = (state_q == S_IDLE);
  assign rsp_o.valid          = (state_q == S_RESP);
  assign rsp_o.status         = status_q;
  assign rsp_o.popped_value   = popped_q;
  assign rsp_o.found          = found_q;
  assign rsp_o.entry_count    = uvst_pkg::ECNT_W'(count_q);
  assign rsp_o.sum_of_entries = acc_sum;
  assign rsp_o.max_entry      = acc_max;
  assign rsp_o.max_valid      = acc_any;

  `UVST_ASSERT(a_count_bound, count_q <= CAP_CNT, "entry count above capacity")
  `UVST_ASSERT_IMP(a_ready_excl, req_i.ready, !rsp_o.valid, "request taken during response")
  `UVST_ASSERT_IMP(a_empty_pop, rsp_o.valid && (rsp_o.status == uvst_pkg::ST_EMPTY), count_q == '0, "empty status with entries held")
  `UVST_ASSERT_IMP(a_max_valid, rsp_o.valid, rsp_o.max_valid == (count_q != '0), "max valid disagrees with count")
  `UVST_ASSERT_IMP(a_rem_range, div_done, {1'b0, div_rem} < (AW + 1)'(count_q), "pop index out of range")

endmodule
